/* rtl/core/ftss_pkg.sv */
`default_nettype none

package ftss_pkg;

    localparam int DATA_W     = 32;  // elapsed, timestep, frame_number
    localparam int RATE_W     = 10;  // min_rate
    localparam int WL_W       = 7;   // window_len
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_MIN_RATE   = 2'd0;
    localparam t_cfg_idx REG_WINDOW_LEN = 2'd1;

endpackage

`default_nettype wire

/* rtl/core/ftss_ram.sv */
`default_nettype none

module ftss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/ftss_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend shifts out at
// the top of r_dvd while quotient bits shift in at the bottom.
module ftss_div #(
    parameter int DIV_W = 38
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [DIV_W-1:0]            i_dividend,
    input  wire logic [ftss_pkg::RATE_W-1:0] i_divisor,
    output logic                             o_done,
    output logic [ftss_pkg::DATA_W-1:0]      o_quotient
);

    import ftss_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic              r_busy, n_busy;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DIV_W-1:0]  r_dvd, n_dvd;
    logic [RATE_W-1:0] r_dvs, n_dvs;
    logic [RATE_W-1:0] r_rem, n_rem;
    logic [RATE_W:0]   rem_sh;
    logic              ge;

    assign rem_sh     = {r_rem, r_dvd[DIV_W-1]};
    assign ge         = rem_sh >= {1'b0, r_dvs};
    assign o_done     = r_busy && (r_cnt == '0);
    assign o_quotient = r_dvd[DATA_W-1:0];

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIV_W);
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt - 1'b1;
                n_dvd = {r_dvd[DIV_W-2:0], ge};
                // when not ge the shifted remainder is below the divisor
                n_rem = ge ? RATE_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[RATE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
    end

endmodule

`default_nettype wire

/* rtl/core/frame_timestep_smoother.sv */
// An accepted item passes S_READ, S_UPDATE (skipped with no window) and S_DONE,
// plus S_LIMDIV when min_rate is set and S_AVGDIV once the window is full.
// Each division runs in the bit-serial divider, shared by the rate clamp and
// the window average; one item in flight: no new item is accepted until the last result is loaded.
// Reset (i_rst_n, synchronous, active low) clears state, config, output valid, running sum,
// fill count, write slot and frame counter; the history RAM is not cleared.
`default_nettype none

module frame_timestep_smoother #(
    parameter int WINDOW_MAX       = 64,
    parameter int TICKS_PER_SECOND = 1000000
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ftss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ftss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [ftss_pkg::DATA_W-1:0]     i_elapsed,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic      [ftss_pkg::DATA_W-1:0]     o_timestep,
    output logic      [ftss_pkg::DATA_W-1:0]     o_frame_number
);

    import ftss_pkg::*;

    localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W  = DATA_W + ((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 0);
    localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
    localparam int DIV_W  = (SUM_W > TPS_W) ? SUM_W : TPS_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LIMDIV = 6'b000010,
        S_READ   = 6'b000100,
        S_UPDATE = 6'b001000,
        S_AVGDIV = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [RATE_W-1:0] r_min_rate, n_min_rate;
    logic [WL_W-1:0]   r_window, n_window;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [WL_W-1:0]   r_fill, n_fill;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [DATA_W-1:0] r_frames, n_frames;
    logic [DATA_W-1:0] r_e, n_e;
    logic [DATA_W-1:0] r_res, n_res;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_timestep, n_timestep;
    logic [DATA_W-1:0] r_frame_no, n_frame_no;

    logic [WL_W-1:0]   eff_len;
    logic              filling;
    logic [SUM_W-1:0]  upd_sum;
    logic [DATA_W-1:0] old_e;
    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [RATE_W-1:0] div_divisor;
    logic              div_done;
    logic [DATA_W-1:0] div_q;
    logic              hist_we;

    assign eff_len = (32'(r_window) > WINDOW_MAX) ? WL_W'(WINDOW_MAX) : r_window;
    assign filling = r_fill < eff_len;
    assign upd_sum = r_sum - (filling ? '0 : SUM_W'(old_e)) + SUM_W'(r_e);
    assign hist_we = (r_state == S_UPDATE);

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_timestep     = r_timestep;
    assign o_frame_number = r_frame_no;

    ftss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW_MAX)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (r_slot),
        .i_wdata (r_e),
        .i_raddr (r_slot),
        .o_rdata (old_e)
    );

    ftss_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        n_state      = r_state;
        n_min_rate   = r_min_rate;
        n_window     = r_window;
        n_sum        = r_sum;
        n_fill       = r_fill;
        n_slot       = r_slot;
        n_frames     = r_frames;
        n_e          = r_e;
        n_res        = r_res;
        n_out_valid  = r_out_valid;
        n_timestep   = r_timestep;
        n_frame_no   = r_frame_no;
        div_start    = 1'b0;
        div_dividend = DIV_W'(TICKS_PER_SECOND);
        div_divisor  = r_min_rate;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_e = i_elapsed;
                    if (r_min_rate != '0) begin
                        div_start = 1'b1;
                        n_state   = S_LIMDIV;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_LIMDIV: begin
                if (div_done) begin
                    n_e     = (r_e > div_q) ? div_q : r_e;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // RAM output holds the entry at r_slot from here on
                if (eff_len == '0) begin
                    n_res   = r_e;
                    n_state = S_DONE;
                end else begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_sum  = upd_sum;
                n_slot = (32'(r_slot) + 32'd1 == 32'(eff_len)) ? '0 : r_slot + 1'b1;
                if (filling) begin
                    n_fill  = r_fill + 1'b1;
                    n_res   = r_e;
                    n_state = S_DONE;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(upd_sum);
                    div_divisor  = RATE_W'(eff_len);
                    n_state      = S_AVGDIV;
                end
            end
            S_AVGDIV: begin
                div_divisor = RATE_W'(eff_len);
                if (div_done) begin
                    n_res   = div_q;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_timestep  = r_res;
                    n_frame_no  = r_frames + 1'b1;
                    n_frames    = r_frames + 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MIN_RATE: begin
                    n_min_rate = i_cfg_data[RATE_W-1:0];
                end
                REG_WINDOW_LEN: begin
                    n_window = i_cfg_data[WL_W-1:0];
                    n_sum    = '0;
                    n_fill   = '0;
                    n_slot   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_min_rate  <= '0;
            r_window    <= '0;
            r_sum       <= '0;
            r_fill      <= '0;
            r_slot      <= '0;
            r_frames    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_min_rate  <= n_min_rate;
            r_window    <= n_window;
            r_sum       <= n_sum;
            r_fill      <= n_fill;
            r_slot      <= n_slot;
            r_frames    <= n_frames;
            r_out_valid <= n_out_valid;
        end
        r_e        <= n_e;
        r_res      <= n_res;
        r_timestep <= n_timestep;
        r_frame_no <= n_frame_no;
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= eff_len)
        else $error("fill count above window length");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (eff_len != '0) |-> (32'(r_slot) < 32'(eff_len)))
        else $error("write slot outside window");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_LIMDIV || r_state == S_AVGDIV))
        else $error("divider finished with no division pending");

    a_frame_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && n_state == S_IDLE) |=> (o_valid && o_frame_number == r_frames))
        else $error("result item not loaded with frame count");
`endif

endmodule

`default_nettype wire

/* test/tb_frame_timestep_smoother.sv */
`timescale 1ns / 100ps

module tb_frame_timestep_smoother;
    import ftss_pkg::*;

    localparam int          WINDOW_MAX       = 64;
    localparam int          TICKS_PER_SECOND = 1000000;
    localparam int          HOLD_CYCLES      = 400;
    localparam int          WATCHDOG_LIMIT   = 4000;
    localparam int          ITEM_TARGET      = 1650;
    localparam int          FINAL_ITEMS      = 80;
    localparam int          DRAIN_CYCLES     = 100;
    localparam logic [31:0] ELAPSED_MAX      = 32'hFFFF_FFFF;

    // indexes with no register behind them
    localparam t_cfg_idx REG_SPARE_2 = 2'd2;
    localparam t_cfg_idx REG_SPARE_3 = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    class timestep_tracker;
        logic [31:0] history [WINDOW_MAX];
        logic [37:0] run_sum;
        int unsigned fill;
        int unsigned slot;
        logic [31:0] frames;
        logic [9:0]  min_rate;
        logic [6:0]  window_len;
        logic [31:0] exp_steps [$];
        logic [31:0] exp_frames [$];
        int          errors;

        function new();
            foreach (history[i]) history[i] = '0;
            run_sum    = '0;
            fill       = 0;
            slot       = 0;
            frames     = '0;
            min_rate   = '0;
            window_len = '0;
            errors     = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MIN_RATE: begin
                    min_rate = data[9:0];
                end
                REG_WINDOW_LEN: begin
                    window_len = data[6:0];
                    run_sum    = '0;
                    fill       = 0;
                    slot       = 0;
                end
                default: ;
            endcase
        endfunction

        function void note_elapsed(logic [31:0] elapsed);
            int unsigned len;
            logic [31:0] e;
            logic [31:0] limit;
            logic [31:0] step;
            len = (window_len > WINDOW_MAX) ? WINDOW_MAX : window_len;
            e = elapsed;
            if (min_rate != 0) begin
                limit = TICKS_PER_SECOND / min_rate;
                if (e > limit) e = limit;
            end
            if (len == 0) begin
                step = e;
            end else begin
                slot = slot % len;
                if (fill < len) begin
                    history[slot] = e;
                    run_sum = run_sum + e;
                    fill++;
                    step = e;
                end else begin
                    run_sum = run_sum - history[slot];
                    history[slot] = e;
                    run_sum = run_sum + e;
                    step = 32'(run_sum / len);
                end
                slot = (slot + 1) % len;
            end
            frames = frames + 1;
            exp_steps  = {exp_steps, step};
            exp_frames = {exp_frames, frames};
        endfunction

        function void check_result(logic [31:0] timestep, logic [31:0] frame_number);
            logic [31:0] want_step;
            logic [31:0] want_frame;
            if (exp_steps.size() == 0) begin
                $display("%0t unexpected item: timestep %0d frame %0d",
                         $time, timestep, frame_number);
                errors++;
                return;
            end
            want_step  = exp_steps.pop_front();
            want_frame = exp_frames.pop_front();
            if (timestep !== want_step) begin
                $display("%0t timestep mismatch: expected %0d, actual %0d",
                         $time, want_step, timestep);
                errors++;
            end
            if (frame_number !== want_frame) begin
                $display("%0t frame_number mismatch: expected %0d, actual %0d",
                         $time, want_frame, frame_number);
                errors++;
            end
        endfunction

        function int pending();
            return exp_steps.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic [DATA_W-1:0]     i_elapsed;
    logic                  o_valid;
    logic                  i_ready;
    logic [DATA_W-1:0]     o_timestep;
    logic [DATA_W-1:0]     o_frame_number;

    timestep_tracker board;
    int  send_idle_pct;
    int  recv_stall_pct;
    logic long_hold;
    int  hold_count;
    int  idle_cycles;
    int  items_sent;

    frame_timestep_smoother #(
        .WINDOW_MAX      (WINDOW_MAX),
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_elapsed     (i_elapsed),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_timestep    (o_timestep),
        .o_frame_number(o_frame_number)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (long_hold && hold_count < HOLD_CYCLES) begin
            i_ready    <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            if (!long_hold) hold_count <= 0;
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (i_valid && o_ready) board.note_elapsed(i_elapsed);
            if (o_valid && i_ready) board.check_result(o_timestep, o_frame_number);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    task automatic set_idle(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            IDLE_SEND: begin send_idle_pct = 87; recv_stall_pct <= 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct <= 87; end
            default:   begin send_idle_pct = 35; recv_stall_pct <= 35; end
        endcase
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(input logic [31:0] elapsed);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid   <= 1'b1;
        i_elapsed <= elapsed;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    // lower valid and let every outstanding result come back
    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_elapsed(input logic [9:0] rate);
        logic [31:0] limit;
        limit = (rate == 0) ? TICKS_PER_SECOND : TICKS_PER_SECOND / rate;
        case ($urandom_range(7))
            0, 1, 2: return $urandom();
            3, 4:    return $urandom_range(0, 2 * limit);
            5:       return $urandom_range(0, 255);
            6:       return $urandom_range(1) ? ELAPSED_MAX : 32'd0;
            default: return limit + $urandom_range(2) - 1;
        endcase
    endfunction

    initial begin
        int          phase;
        int          burst;
        logic [9:0]  rate;
        logic [6:0]  win;
        logic [2:0]  junk;
        t_idle_mode  mode;

        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= REG_MIN_RATE;
        i_cfg_data     <= '0;
        i_valid        <= 1'b0;
        i_elapsed      <= '0;
        i_ready        <= 1'b0;
        recv_stall_pct <= 0;
        long_hold      <= 1'b0;
        hold_count     = 0;
        idle_cycles    = 0;
        items_sent     = 0;
        send_idle_pct  = 0;
        board = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: plain passthrough
        set_idle(IDLE_NONE);
        send_item(32'd0);
        send_item(ELAPSED_MAX);
        send_item(32'd1);
        drain();

        // tightest clamp
        cfg_write(REG_MIN_RATE, 10'd1023);
        send_item(32'd0);
        send_item(32'd977);
        send_item(32'd978);
        send_item(ELAPSED_MAX);
        drain();

        // loosest clamp
        cfg_write(REG_MIN_RATE, 10'd1);
        send_item(32'd1000001);
        send_item(32'd999999);
        drain();

        // short window with max values, sum goes past 32 bits
        cfg_write(REG_MIN_RATE, 10'd0);
        cfg_write(REG_WINDOW_LEN, 10'd3);
        repeat (4) send_item(ELAPSED_MAX);
        send_item(32'd7);
        drain();

        // rewrite of the same window clears history
        cfg_write(REG_WINDOW_LEN, 10'd3);
        send_item(32'd10);
        send_item(32'd20);
        drain();

        // writes to unused indexes change nothing
        cfg_write(REG_SPARE_2, 10'h3FF);
        cfg_write(REG_SPARE_3, 10'h155);
        send_item(32'd30);
        send_item(32'd40);
        drain();

        // window of one, upper data bits ignored
        cfg_write(REG_WINDOW_LEN, 10'h381);
        send_item(32'd5);
        send_item(32'd9);
        send_item(32'd2);
        drain();

        phase = 0;
        while (items_sent < ITEM_TARGET - FINAL_ITEMS) begin
            case ($urandom_range(7))
                0, 4:    rate = 10'd0;
                1:       rate = 10'd1;
                2:       rate = 10'd1023;
                3:       rate = 10'd1000;
                default: rate = 10'($urandom_range(1, 1023));
            endcase
            cfg_write(REG_MIN_RATE, {$urandom_range(1) ? 10'h3FF : 10'h000} & 10'h3FF & rate);
            if (phase == 0 || $urandom_range(2) != 0) begin
                case ($urandom_range(9))
                    0:       win = 7'd0;
                    1:       win = 7'd64;
                    2:       win = 7'($urandom_range(65, 127));
                    3:       win = 7'd1;
                    default: win = 7'($urandom_range(2, 16));
                endcase
                junk = 3'($urandom_range(7));
                cfg_write(REG_WINDOW_LEN, {junk, win});
            end
            if ($urandom_range(5) == 0)
                cfg_write($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                          CFG_DATA_W'($urandom_range(1023)));

            mode = t_idle_mode'(phase % 4);
            if (phase == 5) begin
                // long hold-off: sender keeps offering while results back up
                set_idle(IDLE_NONE);
                long_hold <= 1'b1;
                burst = 30;
            end else begin
                set_idle(mode);
                burst = (board.window_len >= WINDOW_MAX) ? $urandom_range(70, 140)
                                                         : $urandom_range(20, 80);
                if (burst > ITEM_TARGET - FINAL_ITEMS - items_sent)
                    burst = ITEM_TARGET - FINAL_ITEMS - items_sent;
            end
            repeat (burst) send_item(pick_elapsed(board.min_rate));
            if (phase == 5) long_hold <= 1'b0;
            drain();
            phase++;
        end

        // last settings at the extremes
        set_idle(IDLE_BOTH);
        cfg_write(REG_MIN_RATE, 10'd1023);
        cfg_write(REG_WINDOW_LEN, 10'd127);
        repeat (FINAL_ITEMS) send_item(pick_elapsed(10'd1023));
        i_valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/ftss_pkg.sv
rtl/core/ftss_ram.sv
rtl/core/ftss_div.sv
rtl/core/frame_timestep_smoother.sv
test/tb_frame_timestep_smoother.sv
